// ===== rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared widths, codes and defaults for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int PADDR_W = 48;
  localparam int AADDR_W = 25;
  localparam int ST_W    = 2;
  localparam int FCNT_W  = 14;
  localparam int CFG_W   = 14;
  localparam int CIDX_W  = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_FIRST_FREE = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_FREE_END   = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] FIRST_FREE_RST = 14'd512;
  localparam logic [CFG_W-1:0] FREE_END_RST   = 14'd8192;

  // Parameter defaults
  localparam int PAGE_COUNT_DEF = 8192;
  localparam int PAGE_SHIFT_DEF = 12;

endpackage

// ===== rtl/pba_if.sv =====
// ----------------------------------------------------------------------------
// pba_in_if / pba_out_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface pba_in_if
  import pba_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [PADDR_W-1:0] page_address;

  modport source (output valid, output op, output page_address, input ready);
  modport sink   (input valid, input op, input page_address, output ready);
endinterface

interface pba_out_if
  import pba_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [AADDR_W-1:0] alloc_address;
  logic [ST_W-1:0]    status;
  logic [FCNT_W-1:0]  free_count;

  modport source (output valid, output alloc_address, output status, output free_count,
                  input ready);
  modport sink   (input valid, input alloc_address, input status, input free_count,
                  output ready);
endinterface

// ===== rtl/pba_ram.sv =====
// ----------------------------------------------------------------------------
// pba_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/page_bitmap_allocator_unit.sv =====
// Sequence: alloc does group search, word pick and read, modify-write, result; free does
//   word read, modify-write, result; a failed search or out-of-range free goes straight
//   to the result; init sweeps every map word, then gives a result. Throughput: one item
//   at a time, each done before the next is taken. Reset: a synchronous active-low reset
//   starts a sweep of all NW map words (128 at 8192 pages) that fills the map from the
//   reset register values; no item is taken meanwhile, register writes are.
// ----------------------------------------------------------------------------
// page_bitmap_allocator_unit
// First-fit page frame allocator over a free bitmap held in RAM words, with a
// flip-flop summary of nonempty words searched group first, then word.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_unit
  import pba_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pba_in_if.sink            in_ch,
  pba_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int W     = (PAGE_COUNT >= 64) ? 64 : (1 << $clog2(PAGE_COUNT));
  localparam int BI_W  = $clog2(W);
  localparam int NW    = (PAGE_COUNT + W - 1) / W;
  localparam int WI_W  = (NW > 1) ? $clog2(NW) : 1;
  localparam int LG_G  = (WI_W + 1) / 2;
  localparam int G     = 1 << LG_G;
  localparam int NG    = (NW + G - 1) / G;
  localparam int GI_W  = (NG > 1) ? $clog2(NG) : 1;
  localparam int IDX_W = $clog2(PAGE_COUNT);
  localparam int BND_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam int CNT_W = $clog2(PAGE_COUNT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_GRP  = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_RDA  = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  function automatic logic [BND_W-1:0] clip_bound(input logic [CFG_W-1:0] v);
    logic [BND_W-1:0] ext;
    ext = BND_W'(v);
    return (ext > BND_W'(PAGE_COUNT)) ? BND_W'(PAGE_COUNT) : ext;
  endfunction

  // Registers
  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   first_free_r, free_end_r;
  logic [BND_W-1:0]   init_lo_r, init_lo_nxt;
  logic [BND_W-1:0]   init_hi_r, init_hi_nxt;
  logic [WI_W-1:0]    sweep_r, sweep_nxt;
  logic               item_r, item_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [WI_W-1:0]    word_r, word_nxt;
  logic [BI_W-1:0]    bit_r, bit_nxt;
  logic [GI_W-1:0]    grp_r, grp_nxt;
  logic [NG*G-1:0]    summ_r, summ_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [AADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [ST_W-1:0]    st_r, st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [AADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [ST_W-1:0]    out_st_r, out_st_nxt;
  logic [FCNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  // Datapath
  logic               out_free;
  logic               accept;
  logic [PADDR_W-1:0] free_idx;
  logic               free_in_range;
  logic [W-1:0]       fill_mask;
  logic [NG-1:0]      grp_any;
  logic [GI_W-1:0]    grp_pick;
  logic               grp_found;
  logic [G-1:0]       sub_flags;
  logic [LG_G-1:0]    sub_pick;
  logic [WI_W-1:0]    word_pick;
  logic [BI_W-1:0]    bit_pick;
  logic [IDX_W+BI_W+WI_W-1:0] page_idx;
  logic [CNT_W-1:0]   fill_count;

  // RAM port
  logic               ram_we;
  logic [WI_W-1:0]    ram_waddr;
  logic [W-1:0]       ram_wdata;
  logic [WI_W-1:0]    ram_raddr;
  logic [W-1:0]       ram_rdata;

  pba_ram #(
    .WIDTH (W),
    .DEPTH (NW),
    .AW    (WI_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && (state_r == S_IDLE);

  assign free_idx      = in_ch.page_address >> PAGE_SHIFT;
  assign free_in_range = free_idx < PADDR_W'(PAGE_COUNT);

  assign fill_count = (init_hi_r > init_lo_r) ? CNT_W'(init_hi_r - init_lo_r) : '0;

  // Fill pattern for the word under the sweep
  always_comb begin
    logic [BND_W-1:0] g;
    fill_mask = '0;
    for (int j = 0; j < W; j++) begin
      g = BND_W'({sweep_r, BI_W'(j)});
      fill_mask[j] = (g >= init_lo_r) && (g < init_hi_r);
    end
  end

  // First level: lowest group holding a nonempty word
  always_comb begin
    grp_pick  = '0;
    grp_found = 1'b0;
    for (int i = 0; i < NG; i++) begin
      grp_any[i] = |summ_r[i*G +: G];
    end
    for (int i = NG - 1; i >= 0; i--) begin
      if (grp_any[i]) begin
        grp_pick  = GI_W'(i);
        grp_found = 1'b1;
      end
    end
  end

  // Second level: lowest nonempty word in the chosen group
  always_comb begin
    sub_flags = summ_r[{grp_r, LG_G'(0)} +: G];
    sub_pick  = '0;
    for (int i = G - 1; i >= 0; i--) begin
      if (sub_flags[i]) begin
        sub_pick = LG_G'(i);
      end
    end
    word_pick = WI_W'({grp_r, sub_pick});
  end

  // Lowest free bit of the word read back
  always_comb begin
    bit_pick = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (ram_rdata[i]) begin
        bit_pick = BI_W'(i);
      end
    end
  end

  assign page_idx  = (IDX_W + BI_W + WI_W)'({word_r, bit_pick});
  assign ram_raddr = (state_r == S_WRD) ? word_pick : word_r;

  always_comb begin
    state_nxt     = state_r;
    init_lo_nxt   = init_lo_r;
    init_hi_nxt   = init_hi_r;
    sweep_nxt     = sweep_r;
    item_nxt      = item_r;
    op_nxt        = op_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    grp_nxt       = grp_r;
    summ_nxt      = summ_r;
    count_nxt     = count_r;
    res_addr_nxt  = res_addr_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = ram_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt       = in_ch.op;
          word_nxt     = free_idx[BI_W +: WI_W];
          bit_nxt      = free_idx[BI_W-1:0];
          res_addr_nxt = '0;
          st_nxt       = ST_DONE;
          unique case (in_ch.op)
            OP_INIT: begin
              init_lo_nxt = BND_W'(first_free_r);
              init_hi_nxt = clip_bound(free_end_r);
              sweep_nxt   = '0;
              item_nxt    = 1'b1;
              state_nxt   = S_INIT;
            end
            OP_ALLOC: begin
              state_nxt = S_GRP;
            end
            OP_FREE: begin
              if (free_in_range) begin
                state_nxt = S_RDA;
              end else begin
                st_nxt    = ST_RANGE;
                state_nxt = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_INIT: begin
        ram_we            = 1'b1;
        ram_waddr         = sweep_r;
        ram_wdata         = fill_mask;
        summ_nxt[sweep_r] = |fill_mask;
        count_nxt         = fill_count;
        if (sweep_r == WI_W'(NW - 1)) begin
          state_nxt = item_r ? S_EMIT : S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_GRP: begin
        if (grp_found) begin
          grp_nxt   = grp_pick;
          state_nxt = S_WRD;
        end else begin
          st_nxt    = ST_NOFREE;
          state_nxt = S_EMIT;
        end
      end
      S_WRD: begin
        // read is issued at the picked word this cycle
        word_nxt  = word_pick;
        state_nxt = S_MOD;
      end
      S_RDA: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (op_r == OP_ALLOC) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata & ~(W'(1) << bit_pick);
          summ_nxt[word_r] = |ram_wdata;
          count_nxt        = count_r - 1'b1;
          res_addr_nxt     = AADDR_W'({page_idx, {PAGE_SHIFT{1'b0}}});
        end else if (!ram_rdata[bit_r]) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata | (W'(1) << bit_r);
          summ_nxt[word_r] = 1'b1;
          count_nxt        = count_r + 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_st_nxt    = st_r;
          out_cnt_nxt   = FCNT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      first_free_r <= FIRST_FREE_RST;
      free_end_r   <= FREE_END_RST;
      init_lo_r    <= BND_W'(FIRST_FREE_RST);
      init_hi_r    <= clip_bound(FREE_END_RST);
      sweep_r      <= '0;
      item_r       <= 1'b0;
      summ_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_lo_r   <= init_lo_nxt;
      init_hi_r   <= init_hi_nxt;
      sweep_r     <= sweep_nxt;
      item_r      <= item_nxt;
      summ_r      <= summ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_FIRST_FREE: first_free_r <= cfg_wdata;
          CFG_FREE_END:   free_end_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    grp_r      <= grp_nxt;
    count_r    <= count_nxt;
    res_addr_r <= res_addr_nxt;
    st_r       <= st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.alloc_address = out_addr_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.free_count    = out_cnt_r;

endmodule

// ===== rtl/pba_checker.sv =====
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks on the result channel of the page bitmap allocator.
// ----------------------------------------------------------------------------
module pba_checker
  import pba_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [AADDR_W-1:0] out_alloc_address,
  input logic [ST_W-1:0]    out_status,
  input logic [FCNT_W-1:0]  out_free_count
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alloc_address)
      && $stable(out_status) && $stable(out_free_count))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE) || (out_status == ST_NOFREE)
      || (out_status == ST_RANGE))
    else $error("undefined status code");

  a_addr_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_alloc_address != '0) |-> out_status == ST_DONE)
    else $error("address returned with a failing status");

  a_nofree_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOFREE) |-> out_free_count == '0)
    else $error("no free page reported with pages left");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_alloc_address (out_ch.alloc_address),
  .out_status        (out_ch.status),
  .out_free_count    (out_ch.free_count)
);
